// ----- rtl/column_range_change_mask_encoder_unit_macros.svh -----
// assertion macros for the column range change mask encoder checker
`ifndef COLUMN_RANGE_CHANGE_MASK_ENCODER_UNIT_MACROS_SVH
`define COLUMN_RANGE_CHANGE_MASK_ENCODER_UNIT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define CRCME_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define CRCME_ASSERT(lbl, prop, msg) \
    `CRCME_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

// ----- rtl/crcme_pkg.sv -----
// shared types and constants of the column range change mask encoder
package crcme_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int COL_W       = 10;
    localparam int VAL_W       = 64;
    localparam int CMP_W       = 17;
    localparam int ADDR_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_GATHER = 2'd1,
        OP_FINAL  = 2'd2,
        OP_ENCODE = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              inrange;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  value;
        logic              last;
    } item_t;

    typedef struct packed {
        logic             changed;
        logic [VAL_W-1:0] packed_value;
        logic [3:0]       byte_count;
        logic             mask_valid;
        logic [7:0]       mask_byte;
        logic             column_used;
    } res_t;

    typedef struct packed {
        logic init_busy;
    } back_stat_t;

    function automatic logic [ADDR_W-1:0] col_addr(input logic [COL_W-1:0] col);
        logic [ADDR_W+COL_W-1:0] ext;
        begin
            ext = (ADDR_W + COL_W)'(col);
            return ext[ADDR_W-1:0];
        end
    endfunction

    function automatic logic col_inrange(input logic [COL_W-1:0] col);
        return CMP_W'(col) < CMP_W'(MAX_COLUMNS);
    endfunction

endpackage

// ----- rtl/column_range_change_mask_encoder_unit.sv -----
// result: after a request is accepted, ST_EXEC1 reads the tables and ST_EXEC2 loads the result register
// the back end takes a gather, finalize or encode request only once the previous one has passed
//   its table ram read, compute and write-back sequence; a start block sweeps every column,
//   clearing the seen and previous-value tables
// reset: synchronous active low; then a clear of every column of the tables, s_tready low
// a 4-entry queue between front and back lets input flow while a result waits
module column_range_change_mask_encoder_unit import crcme_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // column[9:0], value[73:10], zero fill
    input  logic [1:0]  s_tuser,  // mode[1:0]
    input  logic        s_tlast,  // last_in_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata   // changed[0], packed_value[64:1], byte_count[68:65],
                                  // mask_valid[69], mask_byte[77:70], column_used[78], zero
);

    back_stat_t stat;
    logic       q_valid;
    item_t      q_item;
    logic       q_pop;
    res_t       res;

    crcme_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    crcme_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {1'b0, res.column_used, res.mask_byte, res.mask_valid,
                      res.byte_count, res.packed_value, res.changed};

endmodule

// ----- rtl/crcme_ram.sv -----
// generic single write port ram with registered read
module crcme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/crcme_front.sv -----
// front end: accepts and classifies input requests into a short queue
module crcme_front import crcme_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [79:0] s_tdata,  // column[9:0], value[73:10], zero fill
    input  logic [1:0] s_tuser,   // mode[1:0]
    input  logic       s_tlast,   // last_in_row
    input  back_stat_t stat,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    item_t           fifo_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    item_t           in_item;
    logic            push;

    always_comb begin
        in_item.op      = op_t'(s_tuser);
        in_item.inrange = col_inrange(s_tdata[9:0]);
        in_item.addr    = col_addr(s_tdata[9:0]);
        in_item.value   = s_tdata[73:10];
        in_item.last    = s_tlast;
    end

    assign s_tready = (count_reg != (PW + 1)'(DEPTH)) && !stat.init_busy;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                fifo_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg           <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, q_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/crcme_back.sv -----
// back end: per-column table read-modify-write, mask building and result register
module crcme_back import crcme_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    output back_stat_t stat,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       out_res
);

    typedef enum logic [2:0] {
        ST_CLR_ALL,
        ST_CLR_BLK,
        ST_IDLE,
        ST_EXEC1,
        ST_EXEC2
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              out_valid_reg;
    res_t              res_reg;
    item_t             item_reg;
    logic [VAL_W-1:0]  work_reg;
    logic              gt_reg;
    logic              lt_reg;
    logic [9:0]        row_pos_reg;
    logic [7:0]        mask_acc_reg;

    logic              clr_last;
    logic              seen_rd;
    logic [VAL_W-1:0]  min_rd;
    logic [VAL_W-1:0]  max_rd;
    logic [3:0]        size_rd;
    logic [VAL_W-1:0]  prev_rd;

    logic              seen_we, min_we, max_we, size_we, prev_we;
    logic              seen_wd;
    logic [VAL_W-1:0]  min_wd, max_wd, prev_wd;
    logic [3:0]        size_wd;
    logic [ADDR_W-1:0] waddr;

    res_t              res_next;
    logic [9:0]        row_pos_next;
    logic [7:0]        mask_acc_next;
    logic [VAL_W-1:0]  span;
    logic [3:0]        span_n;
    logic              chg;
    logic [7:0]        acc_or;

    function automatic logic [3:0] span_bytes(input logic [VAL_W-1:0] s);
        logic [3:0] n;
        begin
            n = 4'd1;
            for (int i = 1; i < 8; i++) begin
                if (s[8*i +: 8] != 8'd0) begin
                    n = 4'(i + 1);
                end
            end
            return n;
        end
    endfunction

    function automatic logic [VAL_W-1:0] low_bytes(input logic [VAL_W-1:0] v,
                                                   input logic [3:0] n);
        logic [VAL_W-1:0] r;
        begin
            for (int i = 0; i < 8; i++) begin
                r[8*i +: 8] = (4'(i) < n) ? v[8*i +: 8] : 8'd0;
            end
            return r;
        end
    endfunction

    assign clr_last       = (clr_cnt_reg == ADDR_W'(MAX_COLUMNS - 1));
    assign q_pop          = (state_reg == ST_IDLE) && q_valid && (!out_valid_reg || out_ready);
    assign stat.init_busy = (state_reg == ST_CLR_ALL);
    assign out_valid      = out_valid_reg;
    assign out_res        = res_reg;

    crcme_ram #(.WIDTH(1), .DEPTH(MAX_COLUMNS)) u_seen_ram (
        .aclk(aclk), .we(seen_we), .waddr(waddr), .wdata(seen_wd),
        .re(q_pop), .raddr(q_item.addr), .rdata(seen_rd)
    );
    crcme_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLUMNS)) u_min_ram (
        .aclk(aclk), .we(min_we), .waddr(waddr), .wdata(min_wd),
        .re(q_pop), .raddr(q_item.addr), .rdata(min_rd)
    );
    crcme_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLUMNS)) u_max_ram (
        .aclk(aclk), .we(max_we), .waddr(waddr), .wdata(max_wd),
        .re(q_pop), .raddr(q_item.addr), .rdata(max_rd)
    );
    crcme_ram #(.WIDTH(4), .DEPTH(MAX_COLUMNS)) u_size_ram (
        .aclk(aclk), .we(size_we), .waddr(waddr), .wdata(size_wd),
        .re(q_pop), .raddr(q_item.addr), .rdata(size_rd)
    );
    crcme_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLUMNS)) u_prev_ram (
        .aclk(aclk), .we(prev_we), .waddr(waddr), .wdata(prev_wd),
        .re(q_pop), .raddr(q_item.addr), .rdata(prev_rd)
    );

    // clear sweep and second execute step: table writes and result
    always_comb begin
        span          = max_rd - work_reg;
        span_n        = span_bytes(span);
        chg           = item_reg.inrange && (work_reg != prev_rd);
        acc_or        = mask_acc_reg | (chg ? (8'd1 << row_pos_reg[2:0]) : 8'd0);
        res_next      = '0;
        row_pos_next  = item_reg.last ? 10'd0 : row_pos_reg + 10'd1;
        mask_acc_next = acc_or;

        seen_we = 1'b0;
        min_we  = 1'b0;
        max_we  = 1'b0;
        size_we = 1'b0;
        prev_we = 1'b0;
        seen_wd = 1'b0;
        min_wd  = item_reg.value;
        max_wd  = item_reg.value;
        size_wd = 4'd0;
        prev_wd = work_reg;
        waddr   = item_reg.addr;

        case (state_reg)
            ST_CLR_ALL, ST_CLR_BLK: begin
                waddr   = clr_cnt_reg;
                seen_we = 1'b1;
                prev_we = 1'b1;
                prev_wd = '0;
                size_we = (state_reg == ST_CLR_ALL);
            end
            ST_EXEC2: begin
                case (item_reg.op)
                    OP_GATHER: begin
                        if (item_reg.inrange && item_reg.value != '0) begin
                            seen_we = 1'b1;
                            seen_wd = 1'b1;
                            min_we  = 1'b1;
                            max_we  = 1'b1;
                            min_wd  = (!seen_rd || lt_reg) ? item_reg.value : min_rd;
                            max_wd  = (!seen_rd || gt_reg) ? item_reg.value : max_rd;
                        end
                    end
                    OP_FINAL: begin
                        if (item_reg.inrange) begin
                            size_we = 1'b1;
                            if (seen_rd) begin
                                min_we               = 1'b1;
                                min_wd               = work_reg;
                                size_wd              = span_n;
                                res_next.byte_count  = span_n;
                                res_next.column_used = 1'b1;
                            end
                        end
                    end
                    OP_ENCODE: begin
                        prev_we = item_reg.inrange;
                        if (chg) begin
                            res_next.changed      = 1'b1;
                            res_next.packed_value = low_bytes(work_reg, size_rd);
                            res_next.byte_count   = size_rd;
                        end
                        if (row_pos_reg[2:0] == 3'd7 || item_reg.last) begin
                            res_next.mask_valid = 1'b1;
                            res_next.mask_byte  = acc_or;
                            mask_acc_next       = 8'd0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR_ALL;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            row_pos_reg   <= '0;
            mask_acc_reg  <= '0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR_ALL, ST_CLR_BLK: begin
                    if (clr_last) begin
                        clr_cnt_reg <= '0;
                        state_reg   <= ST_IDLE;
                        if (state_reg == ST_CLR_BLK) begin
                            res_reg       <= '0;
                            out_valid_reg <= 1'b1;
                        end
                    end else begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (q_pop) begin
                        item_reg <= q_item;
                        if (q_item.op == OP_START) begin
                            row_pos_reg  <= '0;
                            mask_acc_reg <= '0;
                            state_reg    <= ST_CLR_BLK;
                        end else begin
                            state_reg <= ST_EXEC1;
                        end
                    end
                end
                ST_EXEC1: begin
                    // ram read data is valid here
                    gt_reg <= item_reg.value > max_rd;
                    lt_reg <= item_reg.value < min_rd;
                    if (item_reg.op == OP_FINAL) begin
                        work_reg <= min_rd - 64'd1;
                    end else begin
                        work_reg <= (item_reg.value != '0) ? item_reg.value - min_rd : '0;
                    end
                    state_reg <= ST_EXEC2;
                end
                ST_EXEC2: begin
                    res_reg       <= res_next;
                    out_valid_reg <= 1'b1;
                    if (item_reg.op == OP_ENCODE) begin
                        row_pos_reg  <= row_pos_next;
                        mask_acc_reg <= mask_acc_next;
                    end
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/crcme_checker.sv -----
// port-level checker for the column range change mask encoder, with its bind
`include "column_range_change_mask_encoder_unit_macros.svh"

module crcme_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // stalled result holds
    `CRCME_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a size is reported only by a changed encode or a used finalize
    `CRCME_ASSERT(a_size_src, m_tvalid && (m_tdata[68:65] != 4'd0) |-> m_tdata[0] || m_tdata[78], "byte count without source")

    `CRCME_ASSERT(a_size_max, m_tvalid |-> (m_tdata[68:65] <= 4'd8), "byte count above eight")

    `CRCME_ASSERT(a_mode_excl, m_tvalid |-> !(m_tdata[0] && m_tdata[78]), "changed and column used together")

    `CRCME_ASSERT(a_mask_gate, m_tvalid && !m_tdata[69] |-> (m_tdata[77:70] == 8'd0), "mask byte without mask valid")

endmodule

bind column_range_change_mask_encoder_unit crcme_checker u_crcme_checker (.*);

// ----- test/column_range_change_mask_encoder_unit_tb.sv -----
`timescale 1ns / 100ps
// testbench for the column range change mask encoder: directed table, then random gather, finalize and encode blocks
module column_range_change_mask_encoder_unit_tb;
    import crcme_pkg::*;

    localparam int DIRECTED_REQUESTS = 25;
    localparam int RANDOM_REQUESTS   = 1250;
    localparam int STALL_LIMIT       = 6000;
    localparam int DRAIN_CYCLES      = 8;

    typedef struct packed {
        op_t         op;
        logic [9:0]  col;
        logic [63:0] val;
        logic        last;
        logic        typed;
        res_t        want;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = OP_START;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    // predictor copy of the column tables
    logic        seen_tbl [MAX_COLUMNS];
    logic [63:0] min_tbl  [MAX_COLUMNS];
    logic [63:0] max_tbl  [MAX_COLUMNS];
    logic [3:0]  size_tbl [MAX_COLUMNS];
    logic [63:0] prev_tbl [MAX_COLUMNS];
    logic [9:0]  row_pos;
    logic [7:0]  mask_acc;

    // columns whose minimum has been written at least once
    bit          range_known [MAX_COLUMNS];

    res_t        pending_results [$];
    res_t        predicted_result;
    res_t        oldest_result;
    dir_row_t    directed_rows [$];
    logic        req_typed = 1'b0;
    res_t        req_want  = '0;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          sent_count     = 0;
    int          ready_hold     = 0;
    bit          quiet          = 1'b0;

    column_range_change_mask_encoder_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic [3:0] span_bytes(input logic [63:0] span);
        logic [3:0] n;
        n = 4'd1;
        while (span >= 64'd256) begin
            n++;
            span = span >> 8;
        end
        return n;
    endfunction

    function automatic logic [63:0] keep_low_bytes(input logic [63:0] v, input logic [3:0] n);
        if (n >= 4'd8)
            return v;
        if (n == 4'd0)
            return '0;
        return v & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic logic [63:0] rand_value(input int nbytes);
        return keep_low_bytes({$urandom, $urandom}, 4'(nbytes));
    endfunction

    // column value near its base, with zeros and extremes mixed in
    function automatic logic [63:0] pick_value(input logic [63:0] base, input int nbytes);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return '0;
        if (roll < 15)
            return '1;
        if (roll < 18)
            return 64'd1;
        return base + rand_value(nbytes);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic predict_encoder_output(input op_t op, input logic [9:0] col,
            input logic [63:0] val, input logic last, output res_t r);
        logic        hit;
        logic        chg;
        logic [2:0]  bit_sel;
        logic [63:0] adj;
        int          i;
        hit = int'(col) < MAX_COLUMNS;
        r = '0;
        chg = 1'b0;
        bit_sel = row_pos[2:0];
        case (op)
            OP_START: begin
                for (i = 0; i < MAX_COLUMNS; i++) begin
                    seen_tbl[i] = 1'b0;
                    prev_tbl[i] = '0;
                end
                row_pos = '0;
                mask_acc = '0;
            end
            OP_GATHER: begin
                if (hit && val != '0) begin
                    if (!seen_tbl[col]) begin
                        min_tbl[col] = val;
                        max_tbl[col] = val;
                        seen_tbl[col] = 1'b1;
                    end else begin
                        if (val > max_tbl[col])
                            max_tbl[col] = val;
                        if (val < min_tbl[col])
                            min_tbl[col] = val;
                    end
                end
            end
            OP_FINAL: begin
                if (hit) begin
                    if (!seen_tbl[col]) begin
                        size_tbl[col] = '0;
                    end else begin
                        min_tbl[col] = min_tbl[col] - 64'd1;
                        size_tbl[col] = span_bytes(max_tbl[col] - min_tbl[col]);
                        r.column_used = 1'b1;
                    end
                    r.byte_count = size_tbl[col];
                end
            end
            OP_ENCODE: begin
                if (hit) begin
                    adj = (val != '0) ? val - min_tbl[col] : '0;
                    chg = adj != prev_tbl[col];
                    prev_tbl[col] = adj;
                    if (chg) begin
                        r.changed = 1'b1;
                        r.packed_value = keep_low_bytes(adj, size_tbl[col]);
                        r.byte_count = size_tbl[col];
                    end
                end
                if (chg)
                    mask_acc[bit_sel] = 1'b1;
                if (bit_sel == 3'd7 || last) begin
                    r.mask_valid = 1'b1;
                    r.mask_byte = mask_acc;
                    mask_acc = '0;
                end
                row_pos = last ? '0 : row_pos + 10'd1;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
            input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic send_request(input op_t op, input logic [9:0] col, input logic [63:0] val,
            input logic last, input logic typed, input res_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tdata   = {6'b0, val, col};
        s_tuser   = op;
        s_tlast   = last;
        req_typed = typed;
        req_want  = want;
        s_tvalid  = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (op == OP_GATHER && val != '0)
            range_known[col] = 1'b1;
        sent_count++;
    endtask

    task automatic add_row(input op_t op, input logic [9:0] col, input logic [63:0] val,
            input logic last, input logic typed, input res_t want);
        dir_row_t row;
        row.op    = op;
        row.col   = col;
        row.val   = val;
        row.last  = last;
        row.typed = typed;
        row.want  = want;
        directed_rows = {directed_rows, row};
    endtask

    // sender holds off until every outstanding request has its result
    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_encoder_output(op_t'(s_tuser), s_tdata[9:0], s_tdata[73:10], s_tlast,
                                       predicted_result);
                pending_results = {pending_results, (req_typed ? req_want : predicted_result)};
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result 0x%0h with no request outstanding", m_tdata);
                    mismatch_count++;
                end else begin
                    oldest_result = pending_results.pop_front();
                    check_field("changed", oldest_result.changed, m_tdata[0]);
                    check_field("packed_value", oldest_result.packed_value, m_tdata[64:1]);
                    check_field("byte_count", oldest_result.byte_count, m_tdata[68:65]);
                    check_field("mask_valid", oldest_result.mask_valid, m_tdata[69]);
                    check_field("mask_byte", oldest_result.mask_byte, m_tdata[77:70]);
                    check_field("column_used", oldest_result.column_used, m_tdata[78]);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready = 1'b0;
            ready_hold--;
        end else begin
            m_tready = 1'b1;
            if ($urandom_range(0, 3) == 0)
                ready_hold = pick_gap();
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [9:0]  block_cols [$];
        int          col_bytes  [$];
        logic [63:0] col_base   [$];
        int          used_idx   [$];
        logic [63:0] last_row_val [MAX_COLUMNS];
        int          ncols;
        int          nrows;
        int          k;
        int          r;
        int          i;
        logic [9:0]  c;
        logic [63:0] v;
        logic        row_end;
        op_t         op;

        for (i = 0; i < MAX_COLUMNS; i++) begin
            seen_tbl[i]     = 1'b0;
            min_tbl[i]      = '0;
            max_tbl[i]      = '0;
            size_tbl[i]     = '0;
            prev_tbl[i]     = '0;
            range_known[i]  = 1'b0;
            last_row_val[i] = '0;
        end
        row_pos  = '0;
        mask_acc = '0;

        add_row(OP_START,  10'd0,    64'd0,       1'b0, 1'b1, '0);
        add_row(OP_FINAL,  10'd5,    64'd0,       1'b0, 1'b1, '0);  // never seen
        add_row(OP_GATHER, 10'd0,    64'd0,       1'b0, 1'b1, '0);  // zero is ignored
        add_row(OP_GATHER, 10'd0,    '1,          1'b0, 1'b1, '0);
        add_row(OP_GATHER, 10'd0,    64'd1,       1'b0, 1'b1, '0);
        add_row(OP_GATHER, 10'd1023, 64'd300,     1'b0, 1'b1, '0);
        add_row(OP_GATHER, 10'd1023, 64'h10000,   1'b0, 1'b1, '0);
        add_row(OP_FINAL,  10'd0,    64'd0,       1'b0, 1'b1,
                res_t'{1'b0, 64'd0, 4'd8, 1'b0, 8'd0, 1'b1});
        add_row(OP_FINAL,  10'd1023, 64'd0,       1'b0, 1'b0, '0);
        add_row(OP_FINAL,  10'd1023, 64'd0,       1'b0, 1'b0, '0);  // second finalize
        add_row(OP_ENCODE, 10'd0,    64'd0,       1'b0, 1'b1, '0);
        add_row(OP_ENCODE, 10'd1023, 64'h10000,   1'b1, 1'b0, '0);
        add_row(OP_ENCODE, 10'd0,    '1,          1'b0, 1'b0, '0);
        add_row(OP_ENCODE, 10'd1023, 64'd5,       1'b1, 1'b0, '0);  // below minimum, wraps
        add_row(OP_ENCODE, 10'd0,    '1,          1'b0, 1'b1, '0);
        add_row(OP_ENCODE, 10'd1023, 64'd5,       1'b1, 1'b1,
                res_t'{1'b0, 64'd0, 4'd0, 1'b1, 8'd0, 1'b0});
        // nine columns in one row: mask byte after the eighth and at row end
        for (i = 0; i < 9; i++)
            add_row(OP_ENCODE, (i % 2 == 0) ? 10'd0 : 10'd1023,
                    (i % 2 == 0) ? 64'h1111 * i : 64'h2000 + i, i == 8, 1'b0, '0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[idx])
            send_request(directed_rows[idx].op, directed_rows[idx].col, directed_rows[idx].val,
                         directed_rows[idx].last, directed_rows[idx].typed,
                         directed_rows[idx].want);
        wait_for_drain();

        while (sent_count < DIRECTED_REQUESTS + RANDOM_REQUESTS) begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) != 0) begin
                wait_for_drain();
                send_request(OP_START, 10'($urandom), rand_value(8), 1'($urandom), 1'b0, '0);
            end

            ncols = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            block_cols.delete();
            col_bytes.delete();
            col_base.delete();
            for (k = 0; k < ncols; k++) begin
                block_cols = {block_cols, (($urandom_range(0, 1) == 0) ?
                                           10'($urandom_range(0, 15)) : 10'($urandom))};
                col_bytes  = {col_bytes, int'($urandom_range(1, 8))};
                col_base   = {col_base, rand_value($urandom_range(1, 8))};
            end

            nrows = $urandom_range(1, 5);
            for (r = 0; r < nrows; r++)
                for (k = 0; k < ncols; k++)
                    send_request(OP_GATHER, block_cols[k], pick_value(col_base[k], col_bytes[k]),
                                 1'($urandom), 1'b0, '0);

            for (k = 0; k < ncols; k++) begin
                send_request(OP_FINAL, block_cols[k], rand_value(8), 1'($urandom), 1'b0, '0);
                if ($urandom_range(0, 19) == 0)
                    send_request(OP_FINAL, block_cols[k], rand_value(8), 1'($urandom), 1'b0, '0);
            end

            // encode only columns whose minimum exists
            used_idx.delete();
            for (k = 0; k < ncols; k++)
                if (range_known[block_cols[k]])
                    used_idx = {used_idx, k};
            if (used_idx.size() > 0) begin
                nrows = $urandom_range(1, 8);
                for (r = 0; r < nrows; r++) begin
                    for (k = 0; k < used_idx.size(); k++) begin
                        c = block_cols[used_idx[k]];
                        if ($urandom_range(0, 3) == 0)
                            v = last_row_val[c];
                        else
                            v = pick_value(col_base[used_idx[k]], col_bytes[used_idx[k]]);
                        last_row_val[c] = v;
                        // now and then the row end is dropped so rows run together
                        row_end = (k == used_idx.size() - 1) && ($urandom_range(0, 7) != 0);
                        send_request(OP_ENCODE, c, v, row_end, 1'b0, '0);
                    end
                end
            end

            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    c = 10'($urandom);
                    op = op_t'($urandom_range(1, 3));
                    if (op == OP_ENCODE && !range_known[c])
                        op = OP_GATHER;
                    send_request(op, c, rand_value($urandom_range(1, 8)), 1'($urandom),
                                 1'b0, '0);
                end
            end
        end

        quiet = 1'b0;
        wait_for_drain();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
